[sv/abm_predictor_corrector_core_macros.svh]
// Assertion macros for the predictor-corrector core.
// Included by the top level; needs i_clk and i_rst_n in the including scope.
`ifndef ABM_PREDICTOR_CORRECTOR_CORE_MACROS_SVH
`define ABM_PREDICTOR_CORRECTOR_CORE_MACROS_SVH

// same-cycle implication
`define ABM_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ABM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/abm_pkg.sv]
// Shared types and constants for the predictor-corrector core.
// No dependencies.
`timescale 1ns / 1ps

package abm_pkg;

    localparam int IDX_W   = 12;
    localparam int DW      = 32;
    localparam int CMD_W   = 2;

    localparam logic [CMD_W-1:0] CMD_PREDICT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CORRECT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET     = 2'd2;

    // input word layout
    localparam int IN_TDATA_W  = 208;
    localparam int DY_LSB      = 12;
    localparam int INIT_LSB    = 108;
    localparam int OUT_TDATA_W = 96;

    // datapath widths
    localparam int S_W    = 36;   // weighted derivative sum, signed
    localparam int M_W    = 35;   // its magnitude
    localparam int P_W    = 51;   // magnitude times 16 bits of dt
    localparam int N_W    = 67;   // full product plus rounding term
    localparam int Q_W    = 34;   // scaled step magnitude
    localparam int V_W    = 33;   // dividend for the divide by three
    localparam int PROD_W = 66;

    // k * 2^31 rounding terms, k = 2 (predict) and k = 12 (correct)
    localparam logic [N_W-1:0] K_PRED = 67'h0_0000_0001_0000_0000;
    localparam logic [N_W-1:0] K_CORR = 67'h0_0000_0006_0000_0000;
    // ceil(2^34 / 3): exact floor(v / 3) for v < 2^33
    localparam logic [V_W-1:0] RECIP3 = 33'h1_5555_5556;
    localparam int RECIP3_SH = 34;

    localparam logic signed [S_W-1:0] SAT_HI = 36'sh0_7FFF_FFFF;
    localparam logic signed [S_W-1:0] SAT_LO = 36'shF_8000_0000;

    typedef logic [2:0][DW-1:0] t_vec;

    typedef struct packed {
        t_vec y0;
        t_vec dy0;
        t_vec dy1;
    } t_entry;

    typedef struct packed {
        logic             vld;
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] idx;
        t_entry           ent;
    } t_hist;

endpackage

[sv/abm_predictor_corrector_core.sv]
// Top level of the AB2/AM3 predictor-corrector core with per-particle history.
// Depends on abm_pkg, abm_ram and abm_predictor_corrector_core_macros.svh.
`timescale 1ns / 1ps
`include "abm_predictor_corrector_core_macros.svh"

// Takes one input word per clock while not stalled and delivers its result word
// from the output register; the rate is set by the single history RAM, which is
// read once and written once per cycle. Each particle's history (last value and
// two older derivatives, 288 bits) sits in that RAM; a read-modify-write of the
// same particle by words in flight is covered by forwarding from the pipeline,
// so any mix of indices runs at full rate. After reset a clearing pass zeroes
// every RAM entry, during which s_axis_tready stays low; dt writes are taken at
// any time. Set-initial, command 3 and out-of-range indices give no output word.
// The pipeline stalls only when its last stage holds a result and the output
// register is full while m_axis_tready is low.
module abm_predictor_corrector_core
    import abm_pkg::*;
#(
    parameter int PARTICLES = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [DW-1:0]          i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // particle_index, deriv_x, deriv_y, deriv_z, init_x, init_y, init_z, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // command
    input  logic [CMD_W-1:0]       s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // out_x, out_y, out_z
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
    localparam logic [20:0] PART_L = 21'(PARTICLES);
    localparam logic [AW-1:0] CLR_LAST = AW'(PARTICLES - 1);

    // control
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;
    logic [DW-1:0] r_dt;
    logic          w_adv;
    logic          w_emit;
    logic          w_fin_wr;
    logic          w_in_ok;

    // stage 1: word accepted, RAM data arrives
    logic             r_p1_vld;
    logic [CMD_W-1:0] r_p1_cmd;
    logic [IDX_W-1:0] r_p1_idx;
    t_vec             r_p1_dy;
    t_vec             r_p1_init;
    t_entry           w_rd;
    t_entry           w_old;
    t_entry           w_new;
    t_vec             w_in_dy;
    t_vec             w_in_init;

    // history carried through stages 2..6, plus last written entry
    t_hist r_h [2:6];
    t_hist w_h2;
    t_hist w_shift [3:5];
    t_hist r_w;

    logic signed [S_W-1:0] w_s  [3];
    logic signed [S_W-1:0] r_s2 [3];
    logic        [M_W-1:0] w_m2 [3];
    logic        [2:0]     w_neg2;
    logic        [M_W-1:0] r_m3 [3];
    logic        [2:0]     r_neg3;
    logic        [P_W-1:0] w_pl3 [3];
    logic        [P_W-1:0] w_ph3 [3];
    logic        [P_W-1:0] r_pl4 [3];
    logic        [P_W-1:0] r_ph4 [3];
    logic        [2:0]     r_neg4;
    logic        [N_W-1:0] w_n4 [3];
    logic        [Q_W-1:0] w_q4 [3];
    logic        [Q_W-1:0] r_q5 [3];
    logic        [2:0]     r_neg5;
    logic     [PROD_W-1:0] w_prod5 [3];
    logic        [Q_W-1:0] w_q5 [3];
    logic        [Q_W-1:0] r_q6 [3];
    logic        [2:0]     r_neg6;
    logic signed [S_W-1:0] w_sum6 [3];
    t_vec                  w_sat;
    t_vec                  w_fin_y0;
    t_entry                w_fin_ent;

    logic                   r_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata;

    // ---------------- handshake ----------------
    assign w_emit   = r_h[6].vld && (r_h[6].cmd != CMD_SET);
    assign w_adv    = !(r_ovalid && !m_axis_tready && w_emit);
    assign w_fin_wr = w_adv && r_h[6].vld;
    assign s_axis_tready = w_adv && !r_clearing;
    assign w_in_ok  = (s_axis_tuser != 2'd3) && (21'(s_axis_tdata[IDX_W-1:0]) < PART_L);

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_in_dy[j]   = s_axis_tdata[DY_LSB + DW*j +: DW];
            w_in_init[j] = s_axis_tdata[INIT_LSB + DW*j +: DW];
        end
    end

    // ---------------- history RAM ----------------
    abm_ram #(
        .WIDTH  ($bits(t_entry)),
        .DEPTH  (PARTICLES),
        .ADDR_W (AW)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (r_clearing || w_fin_wr),
        .i_waddr (r_clearing ? r_clr_addr : AW'(r_h[6].idx)),
        .i_wdata (r_clearing ? '0 : w_fin_ent),
        .i_re    (w_adv),
        .i_raddr (AW'(s_axis_tdata[IDX_W-1:0])),
        .o_rdata (w_rd)
    );

    // ---------------- stage 1: forwarding and weighted sum ----------------
    always_comb begin
        w_old = w_rd;
        if (r_w.vld && (r_w.idx == r_p1_idx)) begin
            w_old = r_w.ent;
        end
        // words still in flight hold newer derivatives; nearest one wins
        for (int k = 6; k >= 2; k--) begin
            if (r_h[k].vld && (r_h[k].idx == r_p1_idx)) begin
                w_old.dy0 = r_h[k].ent.dy0;
                w_old.dy1 = r_h[k].ent.dy1;
            end
        end
        // the value is settled only at the last stage
        if (r_h[6].vld && (r_h[6].idx == r_p1_idx)) begin
            w_old.y0 = w_fin_y0;
        end

        w_new = w_old;
        for (int j = 0; j < 3; j++) begin
            w_s[j] = '0;
        end
        case (r_p1_cmd)
            CMD_PREDICT: begin
                w_new.dy0 = r_p1_dy;
                for (int j = 0; j < 3; j++) begin
                    w_s[j] = (S_W'($signed(r_p1_dy[j])) <<< 1) + S_W'($signed(r_p1_dy[j]))
                           - S_W'($signed(w_old.dy1[j]));
                end
            end
            CMD_CORRECT: begin
                w_new.dy1 = w_old.dy0;
                for (int j = 0; j < 3; j++) begin
                    w_s[j] = (S_W'($signed(r_p1_dy[j])) <<< 2) + S_W'($signed(r_p1_dy[j]))
                           + (S_W'($signed(w_old.dy0[j])) <<< 3)
                           - S_W'($signed(w_old.dy1[j]));
                end
            end
            CMD_SET: begin
                w_new.y0 = r_p1_init;
            end
            default: begin
                w_new = w_old;
            end
        endcase

        w_h2.vld = r_p1_vld;
        w_h2.cmd = r_p1_cmd;
        w_h2.idx = r_p1_idx;
        w_h2.ent = w_new;
    end

    // ---------------- stages 2..5: magnitude, products, scaling ----------------
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_neg2[j] = r_s2[j][S_W-1];
            w_m2[j]   = w_neg2[j] ? M_W'(-r_s2[j]) : M_W'(r_s2[j]);
            w_pl3[j]  = P_W'(r_m3[j]) * P_W'(r_dt[15:0]);
            w_ph3[j]  = P_W'(r_m3[j]) * P_W'(r_dt[31:16]);
            w_n4[j]   = (N_W'(r_ph4[j]) << 16) + N_W'(r_pl4[j])
                      + ((r_h[4].cmd == CMD_CORRECT) ? K_CORR : K_PRED);
            // correct: floor(N / 2^34) still to be divided by three
            w_q4[j]   = (r_h[4].cmd == CMD_CORRECT) ? Q_W'(w_n4[j][N_W-1:34])
                                                    : w_n4[j][N_W-1:33];
            w_prod5[j] = PROD_W'(r_q5[j][V_W-1:0]) * PROD_W'(RECIP3);
            w_q5[j]   = (r_h[5].cmd == CMD_CORRECT)
                      ? Q_W'(w_prod5[j][PROD_W-1:RECIP3_SH]) : r_q5[j];
        end
    end

    // ---------------- stage 6: apply step, saturate ----------------
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_sum6[j] = S_W'($signed(r_h[6].ent.y0[j]))
                      + (r_neg6[j] ? -$signed(S_W'(r_q6[j])) : $signed(S_W'(r_q6[j])));
            if (w_sum6[j] > SAT_HI) begin
                w_sat[j] = SAT_HI[DW-1:0];
            end else if (w_sum6[j] < SAT_LO) begin
                w_sat[j] = SAT_LO[DW-1:0];
            end else begin
                w_sat[j] = w_sum6[j][DW-1:0];
            end
        end
        w_fin_y0      = (r_h[6].cmd == CMD_CORRECT) ? w_sat : r_h[6].ent.y0;
        w_fin_ent     = r_h[6].ent;
        w_fin_ent.y0  = w_fin_y0;
    end

    // younger words of the same particle, other than set-initial ones, pick up the value being written back
    always_comb begin
        for (int k = 2; k <= 4; k++) begin
            w_shift[k+1] = r_h[k];
            if (r_h[6].vld && r_h[k].vld && (r_h[k].idx == r_h[6].idx)
                && (r_h[k].cmd != CMD_SET)) begin
                w_shift[k+1].ent.y0 = w_fin_y0;
            end
        end
    end

    t_hist w_to6;
    always_comb begin
        w_to6 = r_h[5];
        if (r_h[6].vld && r_h[5].vld && (r_h[5].idx == r_h[6].idx)
            && (r_h[5].cmd != CMD_SET)) begin
            w_to6.ent.y0 = w_fin_y0;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_dt       <= '0;
            r_p1_vld   <= 1'b0;
            for (int k = 2; k <= 6; k++) begin
                r_h[k].vld <= 1'b0;
            end
            r_w.vld    <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dt <= i_cfg_wdata;
            end
            if (r_clearing) begin
                if (r_clr_addr == CLR_LAST) begin
                    r_clearing <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
            end
            if (w_adv) begin
                r_p1_vld <= s_axis_tvalid && s_axis_tready && w_in_ok;
                r_h[2]   <= w_h2;
                r_h[3]   <= w_shift[3];
                r_h[4]   <= w_shift[4];
                r_h[5]   <= w_shift[5];
                r_h[6]   <= w_to6;
                r_w.vld  <= r_h[6].vld;
                r_w.idx  <= r_h[6].idx;
                r_w.cmd  <= r_h[6].cmd;
                r_w.ent  <= w_fin_ent;
            end
            if (w_adv && w_emit) begin
                r_ovalid <= 1'b1;
                r_odata  <= w_sat;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p1_cmd  <= s_axis_tuser;
            r_p1_idx  <= s_axis_tdata[IDX_W-1:0];
            r_p1_dy   <= w_in_dy;
            r_p1_init <= w_in_init;
            for (int j = 0; j < 3; j++) begin
                r_s2[j]  <= w_s[j];
                r_m3[j]  <= w_m2[j];
                r_pl4[j] <= w_pl3[j];
                r_ph4[j] <= w_ph3[j];
                r_q5[j]  <= w_q4[j];
                r_q6[j]  <= w_q5[j];
            end
            r_neg3 <= w_neg2;
            r_neg4 <= r_neg3;
            r_neg5 <= r_neg4;
            r_neg6 <= r_neg5;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // ---------------- assertions ----------------
    `ABM_ASSERT(a_no_writeback_in_clear, r_clearing, !w_fin_wr, "write-back during clearing pass")
    `ABM_ASSERT(a_clear_ends_at_last, $fell(r_clearing), r_clr_addr == CLR_LAST, "clearing pass cut short")
    `ABM_ASSERT_NEXT(a_result_loaded, w_adv && w_emit, m_axis_tvalid && (m_axis_tdata == $past(w_sat)), "result word not loaded")
    `ABM_ASSERT_NEXT(a_stall_holds_last, r_h[6].vld && !w_adv, r_h[6].vld && (r_h[6].idx == $past(r_h[6].idx)), "last stage changed while stalled")

endmodule

[sv/abm_ram.sv]
// Generic single-clock RAM, one write port and one registered read port.
// Read during write to the same address returns the old data. No dependencies.
`timescale 1ns / 1ps

module abm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
